>>> rtl/core/q4k_pkg.sv
// shared types, constants and helpers for the q4_k block dequantizer
`timescale 1ns / 1ps

package q4k_pkg;

  localparam int unsigned WeightW = 51;
  localparam int unsigned MantW   = 11;
  localparam int unsigned MultW   = 10;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned ProdW   = MantW + MultW;

  localparam logic [7:0] PosScaleLo   = 8'd0;
  localparam logic [7:0] PosScaleHi   = 8'd1;
  localparam logic [7:0] PosMinLo     = 8'd2;
  localparam logic [7:0] PosMinHi     = 8'd3;
  localparam logic [7:0] QuantStart   = 8'd16;
  localparam logic [7:0] LastPos      = 8'd143;
  localparam logic [3:0] PackedBase   = 4'd4;
  localparam logic [4:0] ExpNonFinite = 5'h1F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO_D,
    ST_LO_M,
    ST_HI_D,
    ST_HI_M
  } state_e;

  typedef enum logic {
    OP_LOAD,
    OP_SUB
  } mac_op_e;

  // half float split into integer mantissa and left shift (units of 2^-24)
  typedef struct packed {
    logic              neg;
    logic [MantW-1:0]  mant;
    logic [ShiftW-1:0] shift;
  } half_t;

  typedef struct packed {
    logic [5:0] scale;
    logic [5:0] minimum;
  } pair_t;

  typedef struct packed {
    logic    take;
    logic    quant;
    logic    mac_en;
    mac_op_e op;
    logic    hi;
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic              en;
    mac_op_e           op;
    logic              neg;
    logic [MantW-1:0]  mant;
    logic [MultW-1:0]  mult;
    logic [ShiftW-1:0] shift;
  } mac_req_t;

  function automatic half_t half_decode(logic [15:0] h);
    half_t r;
    r.neg = h[15];
    if (h[14:10] == 5'd0) begin
      r.mant  = {1'b0, h[9:0]};
      r.shift = '0;
    end else begin
      r.mant  = {1'b1, h[9:0]};
      r.shift = h[14:10] - 5'd1;
    end
    return r;
  endfunction

  function automatic logic half_nonfinite(logic [15:0] h);
    return h[14:10] == ExpNonFinite;
  endfunction

endpackage

>>> rtl/core/q4k_block_dequantizer_unit.sv
// top level of the q4_k block dequantizer
//
// input channel: one beat per block byte (block_byte_i), 144 bytes per block in
// stored order. the first 16 bytes are header (super-scale, super-minimum and
// twelve packed scale/min bytes) and give no result. each of the 128 quant
// bytes gives two result beats: the low nibble first, then the high nibble at
// value_index + 32. weight_value_o is d*scale*q - dmin*min, exact, in signed
// units of 2^-24; nonfinite_o flags an inf/NaN header half and then the
// weight reads 0. last_of_block_o marks value_index 255.
// a header byte does not stall the input; a quant byte holds the input stalled
// after its beat until both of its weights have entered the output register,
// because one shared multiply-shift-accumulate unit forms each weight in two
// passes (scale term, then minimum term). the first result passes through the
// scale*q register, the accumulator and the output register. a finished result
// sits in an output register, so the next byte is taken while it waits. when
// out_stall_i holds the result, the sequencer waits in its minimum-term step
// and the input stays stalled. reset clears the block position to the first
// header byte and empties the output register.
`timescale 1ns / 1ps

module q4k_block_dequantizer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          block_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          value_index_o,
  output logic signed [q4k_pkg::WeightW-1:0]  weight_value_o,
  output logic                                nonfinite_o,
  output logic                                last_of_block_o
);
  import q4k_pkg::*;

  ctrl_t                      ctrl;
  logic [7:0]                 pos;
  logic [1:0]                 group;
  logic [7:0]                 index;
  logic                       last;
  logic                       out_free;
  half_t                      d_half;
  half_t                      dmin_half;
  logic                       hdr_nonfinite;
  pair_t                      pair_lo;
  pair_t                      pair_hi;
  mac_req_t                   mac_req;
  logic signed [WeightW-1:0]  acc_next;

  logic [MultW-1:0]           mult_lo_q;
  logic [MultW-1:0]           mult_hi_q;
  logic [5:0]                 min_lo_q;
  logic [5:0]                 min_hi_q;
  logic                       out_valid_q;
  logic [7:0]                 index_q;
  logic signed [WeightW-1:0]  weight_q;
  logic                       nonfinite_q;
  logic                       last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  q4k_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl),
    .pos_o      (pos),
    .group_o    (group),
    .index_o    (index),
    .last_o     (last)
  );

  q4k_hdr u_hdr (
    .clk_i       (clk_i),
    .wr_en_i     (ctrl.take),
    .pos_i       (pos),
    .byte_i      (block_byte_i),
    .group_i     (group),
    .d_o         (d_half),
    .dmin_o      (dmin_half),
    .nonfinite_o (hdr_nonfinite),
    .pair_lo_o   (pair_lo),
    .pair_hi_o   (pair_hi)
  );

  // scale*q is formed at the input beat so the shared unit sees one product
  always_ff @(posedge clk_i) begin
    if (ctrl.quant) begin
      mult_lo_q <= MultW'(pair_lo.scale) * MultW'(block_byte_i[3:0]);
      mult_hi_q <= MultW'(pair_hi.scale) * MultW'(block_byte_i[7:4]);
      min_lo_q  <= pair_lo.minimum;
      min_hi_q  <= pair_hi.minimum;
    end
  end

  always_comb begin
    mac_req.en = ctrl.mac_en;
    mac_req.op = ctrl.op;
    unique case (ctrl.op)
      OP_LOAD: begin
        mac_req.neg   = d_half.neg;
        mac_req.mant  = d_half.mant;
        mac_req.shift = d_half.shift;
        mac_req.mult  = ctrl.hi ? mult_hi_q : mult_lo_q;
      end
      OP_SUB: begin
        mac_req.neg   = dmin_half.neg;
        mac_req.mant  = dmin_half.mant;
        mac_req.shift = dmin_half.shift;
        mac_req.mult  = MultW'(ctrl.hi ? min_hi_q : min_lo_q);
      end
      default: begin
        mac_req.neg   = d_half.neg;
        mac_req.mant  = d_half.mant;
        mac_req.shift = d_half.shift;
        mac_req.mult  = mult_lo_q;
      end
    endcase
  end

  q4k_mac u_mac (
    .clk_i      (clk_i),
    .req_i      (mac_req),
    .acc_next_o (acc_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      index_q     <= index;
      weight_q    <= hdr_nonfinite ? '0 : acc_next;
      nonfinite_q <= hdr_nonfinite;
      last_q      <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_index_o   = index_q;
  assign weight_value_o  = weight_q;
  assign nonfinite_o     = nonfinite_q;
  assign last_of_block_o = last_q;

endmodule

>>> rtl/core/q4k_hdr.sv
// block header store: super-scale, super-minimum and packed 6-bit scale/min pairs
`timescale 1ns / 1ps

module q4k_hdr (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [7:0]      pos_i,
  input  logic [7:0]      byte_i,
  input  logic [1:0]      group_i,
  output q4k_pkg::half_t  d_o,
  output q4k_pkg::half_t  dmin_o,
  output logic            nonfinite_o,
  output q4k_pkg::pair_t  pair_lo_o,
  output q4k_pkg::pair_t  pair_hi_o
);
  import q4k_pkg::*;

  logic [15:0]       d_q;
  logic [15:0]       dmin_q;
  logic [11:0][7:0]  pb_q;
  pair_t             pairs [8];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (pos_i < QuantStart)) begin
      priority if (pos_i == PosScaleLo) begin
        d_q[7:0] <= byte_i;
      end else if (pos_i == PosScaleHi) begin
        d_q[15:8] <= byte_i;
      end else if (pos_i == PosMinLo) begin
        dmin_q[7:0] <= byte_i;
      end else if (pos_i == PosMinHi) begin
        dmin_q[15:8] <= byte_i;
      end else begin
        pb_q[pos_i[3:0] - PackedBase] <= byte_i;
      end
    end
  end

  // every pair unpacked from fixed byte positions
  for (genvar j = 0; j < 8; j++) begin : g_pair
    if (j < 4) begin : g_plain
      assign pairs[j].scale   = pb_q[j][5:0];
      assign pairs[j].minimum = pb_q[j+4][5:0];
    end else begin : g_split
      assign pairs[j].scale   = {pb_q[j-4][7:6], pb_q[j+4][3:0]};
      assign pairs[j].minimum = {pb_q[j][7:6], pb_q[j+4][7:4]};
    end
  end

  assign pair_lo_o   = pairs[{group_i, 1'b0}];
  assign pair_hi_o   = pairs[{group_i, 1'b1}];
  assign d_o         = half_decode(d_q);
  assign dmin_o      = half_decode(dmin_q);
  assign nonfinite_o = half_nonfinite(d_q) || half_nonfinite(dmin_q);

endmodule

>>> rtl/core/q4k_mac.sv
// shared multiply-shift-accumulate unit: acc = +/-(mant*mult << shift), or acc minus that
`timescale 1ns / 1ps

module q4k_mac (
  input  logic                                    clk_i,
  input  q4k_pkg::mac_req_t                       req_i,
  output logic signed [q4k_pkg::WeightW-1:0]      acc_next_o
);
  import q4k_pkg::*;

  logic        [ProdW-1:0]   prod;
  logic signed [WeightW-1:0] mag;
  logic signed [WeightW-1:0] term;
  logic signed [WeightW-1:0] acc_q;
  logic signed [WeightW-1:0] acc_d;

  always_comb begin
    prod = req_i.mant * req_i.mult;
    mag  = WeightW'(prod) << req_i.shift;
    term = req_i.neg ? -mag : mag;
    unique case (req_i.op)
      OP_LOAD: acc_d = term;
      OP_SUB:  acc_d = acc_q - term;
      default: acc_d = term;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_next_o = acc_d;

endmodule

>>> rtl/core/q4k_seq.sv
// sequencer: block position, input handshake and the four-step schedule per quant byte
`timescale 1ns / 1ps

module q4k_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  output logic            in_stall_o,
  output q4k_pkg::ctrl_t  ctrl_o,
  output logic [7:0]      pos_o,
  output logic [1:0]      group_o,
  output logic [7:0]      index_o,
  output logic            last_o
);
  import q4k_pkg::*;

  state_e      state_q;
  state_e      state_d;
  logic [7:0]  pos_q;
  logic [7:0]  k_cur;
  logic [6:0]  k_q;
  logic        end_q;
  logic        take;
  logic        is_quant;

  assign take     = in_valid_i && (state_q == ST_IDLE);
  assign is_quant = pos_q >= QuantStart;
  assign k_cur    = pos_q - QuantStart;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && is_quant) begin
          state_d = ST_LO_D;
        end
      end
      ST_LO_D: state_d = ST_LO_M;
      ST_LO_M: begin
        if (out_free_i) begin
          state_d = ST_HI_D;
        end
      end
      ST_HI_D: state_d = ST_HI_M;
      ST_HI_M: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.op    = OP_LOAD;
    ctrl_o.take  = take;
    ctrl_o.quant = take && is_quant;
    unique case (state_q)
      ST_IDLE: ;
      ST_LO_D: ctrl_o.mac_en = 1'b1;
      ST_LO_M: begin
        ctrl_o.op     = OP_SUB;
        ctrl_o.mac_en = out_free_i;
        ctrl_o.emit   = out_free_i;
      end
      ST_HI_D: begin
        ctrl_o.hi     = 1'b1;
        ctrl_o.mac_en = 1'b1;
      end
      ST_HI_M: begin
        ctrl_o.hi     = 1'b1;
        ctrl_o.op     = OP_SUB;
        ctrl_o.mac_en = out_free_i;
        ctrl_o.emit   = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        pos_q <= (pos_q == LastPos) ? '0 : pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_quant) begin
      k_q   <= k_cur[6:0];
      end_q <= pos_q == LastPos;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign pos_o      = pos_q;
  assign group_o    = k_cur[6:5];
  // low nibble lands in the first half of the group, high nibble 32 further on
  assign index_o    = {k_q[6:5], ctrl_o.hi, k_q[4:0]};
  assign last_o     = ctrl_o.hi && end_q;

endmodule

>>> rtl/core/q4k_chk.sv
// port-level checker for the q4_k block dequantizer, bound to the top level
`timescale 1ns / 1ps

module q4k_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [7:0]                          value_index_o,
  input logic signed [q4k_pkg::WeightW-1:0]  weight_value_o,
  input logic                                nonfinite_o,
  input logic                                last_of_block_o
);
  import q4k_pkg::*;

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_index_o) && $stable(weight_value_o)
      && $stable(nonfinite_o) && $stable(last_of_block_o))
    else $error("result beat changed while stalled");

  // results are only produced while a quant byte is in work
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a quant byte in work");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_block_o |-> value_index_o == 8'hFF)
    else $error("block end flagged on a result other than the final one");

  a_nonfinite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nonfinite_o |-> weight_value_o == '0)
    else $error("non-finite result carries a nonzero weight");

endmodule

bind q4k_block_dequantizer_unit q4k_chk u_q4k_chk (.*);

>>> tb/tb_q4k_block_dequantizer_unit.sv
// testbench for the q4_k block dequantizer: random stalls, scoreboard prediction
`timescale 1ns / 1ps

module tb_q4k_block_dequantizer_unit;
  import q4k_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold  = 400;
  localparam int unsigned RandBlocks = 5;

  typedef struct {
    logic [7:0]                index;
    logic signed [WeightW-1:0] weight;
    logic                      nonfinite;
    logic                      last;
  } weight_beat_t;

  class dequant_scoreboard;
    logic [7:0]  pos;
    logic [15:0] d_half;
    logic [15:0] m_half;
    logic [7:0]  scale_bytes [12];
    weight_beat_t weight_q[$];
    int unsigned errors;
    int unsigned weights_seen;
    int unsigned flagged;

    function new();
      pos = '0;
      d_half = '0;
      m_half = '0;
      errors = 0;
      weights_seen = 0;
      flagged = 0;
    endfunction

    function longint half_units(logic [15:0] h);
      longint mag;
      if (h[14:10] == 5'd0) begin
        mag = longint'(h[9:0]);
      end else begin
        mag = (longint'(1024) + longint'(h[9:0])) << (h[14:10] - 5'd1);
      end
      return h[15] ? -mag : mag;
    endfunction

    function void pair_of(int j, output logic [5:0] sc, output logic [5:0] mn);
      if (j < 4) begin
        sc = scale_bytes[j][5:0];
        mn = scale_bytes[j+4][5:0];
      end else begin
        sc = {scale_bytes[j-4][7:6], scale_bytes[j+4][3:0]};
        mn = {scale_bytes[j][7:6], scale_bytes[j+4][7:4]};
      end
    endfunction

    function weight_beat_t predict_weight(logic [7:0] idx, int j, logic [3:0] q,
                                          logic last);
      weight_beat_t r;
      logic [5:0] sc;
      logic [5:0] mn;
      longint w;
      logic bad;
      bad = (d_half[14:10] == ExpNonFinite) || (m_half[14:10] == ExpNonFinite);
      w = 0;
      if (!bad) begin
        pair_of(j, sc, mn);
        w = half_units(d_half) * (longint'(sc) * longint'(q)) -
            half_units(m_half) * longint'(mn);
      end
      r.index = idx;
      r.weight = w[WeightW-1:0];
      r.nonfinite = bad;
      r.last = last;
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] k;
      logic [7:0] base;
      k = pos - QuantStart;
      base = {k[6:5], 1'b0, k[4:0]};
      if (pos == PosScaleLo) begin
        d_half[7:0] = b;
      end else if (pos == PosScaleHi) begin
        d_half[15:8] = b;
      end else if (pos == PosMinLo) begin
        m_half[7:0] = b;
      end else if (pos == PosMinHi) begin
        m_half[15:8] = b;
      end else if (pos < QuantStart) begin
        scale_bytes[pos[3:0] - PackedBase] = b;
      end else begin
        // low nibble first, high nibble lands 32 further on
        weight_q.push_back(predict_weight(base, 2 * k[6:5], b[3:0], 1'b0));
        weight_q.push_back(predict_weight(base | 8'd32, 2 * k[6:5] + 1, b[7:4],
                                          pos == LastPos));
      end
      pos = (pos == LastPos) ? 8'd0 : pos + 8'd1;
    endfunction

    function void check_result(logic [7:0] idx, logic signed [WeightW-1:0] w,
                               logic nf, logic last);
      weight_beat_t e;
      if (weight_q.size() == 0) begin
        $error("unexpected beat: value_index %0d weight_value %0d", idx, w);
        errors++;
        return;
      end
      e = weight_q.pop_front();
      weights_seen++;
      if (nf) flagged++;
      if (idx !== e.index) begin
        $error("value_index: expected %0d, got %0d", e.index, idx);
        errors++;
      end
      if (w !== e.weight) begin
        $error("weight_value: expected %0d, got %0d", e.weight, w);
        errors++;
      end
      if (nf !== e.nonfinite) begin
        $error("nonfinite: expected %0b, got %0b", e.nonfinite, nf);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_block: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return weight_q.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                block_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [7:0]                value_index;
  logic signed [WeightW-1:0] weight_value;
  logic                      nonfinite;
  logic                      last_of_block;

  dequant_scoreboard sb;
  int unsigned idle_cycles = 0;
  int unsigned blocks_sent;

  q4k_block_dequantizer_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .block_byte_i    (block_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .value_index_o   (value_index),
    .weight_value_o  (weight_value),
    .nonfinite_o     (nonfinite),
    .last_of_block_o (last_of_block)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    block_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  // quant_mode 1 cycles through the nibble extremes, 0 is random
  task automatic send_block(input logic [15:0] d, input logic [15:0] dm,
                            input logic [95:0] pk, input int quant_mode,
                            input bit quiet);
    logic [7:0] b;
    for (int i = 0; i < 144; i++) begin
      if (i < 2) begin
        b = d[8*i +: 8];
      end else if (i < 4) begin
        b = dm[8*(i-2) +: 8];
      end else if (i < 16) begin
        b = pk[8*(i-4) +: 8];
      end else if (quant_mode == 1) begin
        case (i % 4)
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = 8'h0F;
          default: b = 8'hF0;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b, quiet ? 0 : $urandom_range(0, 6));
    end
    blocks_sent++;
  endtask

  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 7))
      0: h[14:10] = 5'd0;
      1: h[14:10] = ExpNonFinite;
      2: h[14:10] = 5'd30;
      default: ;
    endcase
    return h;
  endfunction

  function automatic logic [95:0] rand_packed();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom, $urandom};
    endcase
  endfunction

  // receiver: random stall per beat, one long hold-off, and calm stretches
  initial begin
    int unsigned beats;
    int gap;
    bit held;
    beats = 0;
    held = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, 6);
      if ((beats / 128) % 4 == 1) gap = 0;
      if (beats == 500 && !held) begin
        gap = LongHold;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid || out_stall) @(posedge clk);
      beats++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(value_index, weight_value, nonfinite, last_of_block);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    blocks_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    block_byte = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest positive weights, then subnormals, then inf and NaN headers
    send_block(16'h7BFF, 16'hFBFF, '1, 1, 1'b0);
    send_block(16'h8001, 16'h03FF, {$urandom, $urandom, $urandom}, 1, 1'b1);
    send_block(16'h7C00, 16'h0000, {$urandom, $urandom, $urandom}, 0, 1'b0);
    send_block(16'h0000, 16'hFE01, '0, 1, 1'b0);

    for (int n = 0; n < RandBlocks; n++) begin
      send_block(rand_half(), rand_half(), rand_packed(), 0,
                 $urandom_range(0, 3) == 0);
      if (n == 3) begin
        // drain completely before the next block
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("ran %0d blocks: %0d weights checked, %0d of them flagged non-finite",
             blocks_sent, sb.weights_seen, sb.flagged);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> q4k_block_dequantizer_unit.f
rtl/core/q4k_pkg.sv
rtl/core/q4k_hdr.sv
rtl/core/q4k_mac.sv
rtl/core/q4k_seq.sv
rtl/core/q4k_block_dequantizer_unit.sv
rtl/core/q4k_chk.sv
tb/tb_q4k_block_dequantizer_unit.sv
